[rtl/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the planar partition scan-out block.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int unsigned CFG_W       = 32;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned LINES_W     = 10;
    localparam int unsigned ROW_W       = 9;
    localparam int unsigned COL_W       = 10;
    localparam int unsigned RBP_W       = 11;
    localparam int unsigned PIDX_W      = 3;
    localparam int unsigned GROUP_W     = 24;
    localparam int unsigned PLANE_W     = 8;
    localparam int unsigned NUM_PARTS   = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LINES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_0       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_1       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_2       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_3       = 3'd4;

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    // partition word layout
    localparam int unsigned PW_WIDE_BIT  = 31;
    localparam int unsigned PW_LINES_HI  = 29;
    localparam int unsigned PW_LINES_LO  = 20;

    typedef logic [NUM_PARTS-1:0][CFG_W-1:0] part_words_t;

    typedef struct packed {
        logic                  pixels_valid;
        logic [GROUP_W-1:0]    pixel_group;
        logic                  doubled;
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      column;
        logic [ADDR_W-1:0]     fetch_addr;
        logic                  frame_done;
    } result_t;

    typedef struct packed {
        logic                  found;
        logic [PIDX_W-1:0]     index;
        logic [RBP_W-1:0]      rows_before;
        logic [ROW_W-1:0]      row;
        logic [ADDR_W-1:0]     word_ptr;
    } seek_t;

endpackage

[rtl/pps_pixel_pack.sv]
// ----------------------------------------------------------------------------
// pps_pixel_pack
// Interleaves three plane bytes into eight 3-bit pixels.
// ----------------------------------------------------------------------------
module pps_pixel_pack
(
    input  logic [pps_pkg::PLANE_W-1:0] blue,
    input  logic [pps_pkg::PLANE_W-1:0] red,
    input  logic [pps_pkg::PLANE_W-1:0] green,
    output logic [pps_pkg::GROUP_W-1:0] group
);
    import pps_pkg::*;

    always_comb
    begin
        for (int k = 0; k < PLANE_W; k++)
        begin
            group[3*k]   = red[k];
            group[3*k+1] = green[k];
            group[3*k+2] = blue[k];
        end
    end

endmodule

[rtl/pps_partition_seek.sv]
// ----------------------------------------------------------------------------
// pps_partition_seek
// Finds the next partition, from a given index on, that has rows to draw.
// ----------------------------------------------------------------------------
module pps_partition_seek
#(
    parameter int unsigned SCREEN_ROWS     = 400,
    parameter int unsigned PARTITION_COUNT = 4
)
(
    input  logic [pps_pkg::PIDX_W-1:0]  start_index,
    input  logic [pps_pkg::RBP_W-1:0]   start_rows,
    input  logic [pps_pkg::LINES_W-1:0] active_lines,
    input  pps_pkg::part_words_t        part_words,
    output pps_pkg::seek_t              seek
);
    import pps_pkg::*;

    localparam logic [RBP_W-1:0]  ROWS_LIM  = RBP_W'(SCREEN_ROWS);
    localparam logic [PIDX_W-1:0] PART_LIM  = PIDX_W'(PARTITION_COUNT);

    logic [PIDX_W-1:0]  idx;
    logic [RBP_W-1:0]   rbp;
    logic [LINES_W-1:0] lines;
    logic [CFG_W-1:0]   word;
    logic               found;
    logic               stopped;

    always_comb
    begin
        idx     = start_index;
        rbp     = start_rows;
        found   = 1'b0;
        stopped = 1'b0;
        word    = '0;
        lines   = '0;
        seek.word_ptr = '0;
        for (int j = 0; j < NUM_PARTS; j++)
        begin
            if (!found && !stopped)
            begin
                if (idx < PART_LIM && rbp < RBP_W'(active_lines))
                begin
                    word  = part_words[idx[1:0]];
                    lines = word[PW_LINES_HI:PW_LINES_LO];
                    if (lines != '0 && rbp < ROWS_LIM)
                    begin
                        found         = 1'b1;
                        seek.word_ptr = {word[ADDR_W-2:0], 1'b0};
                    end
                    else
                    begin
                        rbp = rbp + RBP_W'(lines);
                        idx = idx + 1'b1;
                    end
                end
                else
                begin
                    stopped = 1'b1;
                end
            end
        end
        seek.found       = found;
        seek.index       = idx;
        seek.rows_before = rbp;
        seek.row         = rbp[ROW_W-1:0];
    end

endmodule

[rtl/pps_scan_ctrl.sv]
// ----------------------------------------------------------------------------
// pps_scan_ctrl
// Scan state registers and the per-item next-state and result logic.
// ----------------------------------------------------------------------------
module pps_scan_ctrl
#(
    parameter int unsigned SCREEN_ROWS     = 400,
    parameter int unsigned SCREEN_COLS     = 640,
    parameter int unsigned PARTITION_COUNT = 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        kind,
    input  logic [pps_pkg::PLANE_W-1:0] plane_blue,
    input  logic [pps_pkg::PLANE_W-1:0] plane_red,
    input  logic [pps_pkg::PLANE_W-1:0] plane_green,
    input  logic [pps_pkg::LINES_W-1:0] active_lines,
    input  pps_pkg::part_words_t        part_words,
    output pps_pkg::result_t            result_next
);
    import pps_pkg::*;

    localparam logic [COL_W:0] COLS_LIM = (COL_W+1)'(SCREEN_COLS);
    localparam logic [ROW_W:0] ROWS_LIM = (ROW_W+1)'(SCREEN_ROWS);

    logic [PIDX_W-1:0] pidx_reg,     pidx_next;
    logic [RBP_W-1:0]  rbp_reg,      rbp_next;
    logic [ROW_W-1:0]  row_reg,      row_next;
    logic [COL_W-1:0]  col_reg,      col_next;
    logic [ADDR_W-1:0] wptr_reg,     wptr_next;
    logic              scanning_reg, scanning_next;

    logic [CFG_W-1:0]   cur_word;
    logic [LINES_W-1:0] cur_lines;
    logic               wide;
    logic [COL_W:0]     col_sum;
    logic [ROW_W:0]     row_inc;
    logic [RBP_W:0]     row_end;
    logic [ADDR_W-1:0]  wptr_inc;
    logic [GROUP_W-1:0] group;
    logic               is_start;
    logic [PIDX_W-1:0]  seek_idx;
    logic [RBP_W-1:0]   seek_rbp;
    seek_t              seek;

    assign is_start  = (kind == KIND_START);
    assign cur_word  = part_words[pidx_reg[1:0]];
    assign cur_lines = cur_word[PW_LINES_HI:PW_LINES_LO];
    assign wide      = cur_word[PW_WIDE_BIT];
    assign col_sum   = (COL_W+1)'(col_reg) + (wide ? (COL_W+1)'(16) : (COL_W+1)'(8));
    assign row_inc   = (ROW_W+1)'(row_reg) + 1'b1;
    assign row_end   = (RBP_W+1)'(rbp_reg) + (RBP_W+1)'(cur_lines);
    assign wptr_inc  = wptr_reg + 1'b1;
    assign seek_idx  = is_start ? '0 : pidx_reg + 1'b1;
    assign seek_rbp  = is_start ? '0 : RBP_W'(row_end);

    pps_pixel_pack u_pack
    (
        .blue  (plane_blue),
        .red   (plane_red),
        .green (plane_green),
        .group (group)
    );

    pps_partition_seek
    #(
        .SCREEN_ROWS     (SCREEN_ROWS),
        .PARTITION_COUNT (PARTITION_COUNT)
    )
    u_seek
    (
        .start_index  (seek_idx),
        .start_rows   (seek_rbp),
        .active_lines (active_lines),
        .part_words   (part_words),
        .seek         (seek)
    );

    always_comb
    begin
        pidx_next     = pidx_reg;
        rbp_next      = rbp_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        wptr_next     = wptr_reg;
        scanning_next = scanning_reg;
        result_next   = '0;

        if (is_start)
        begin
            pidx_next     = seek.index;
            rbp_next      = seek.rows_before;
            row_next      = seek.found ? seek.row : '0;
            col_next      = '0;
            wptr_next     = seek.word_ptr;
            scanning_next = seek.found;
        end
        else if (scanning_reg)
        begin
            result_next.pixels_valid = 1'b1;
            result_next.pixel_group  = group;
            result_next.doubled      = wide;
            result_next.row          = row_reg;
            result_next.column       = col_reg;
            wptr_next                = wptr_inc;
            col_next                 = col_sum[COL_W-1:0];
            if (col_sum >= COLS_LIM)
            begin
                col_next = '0;
                if ((RBP_W+1)'(row_inc) >= row_end || row_inc >= ROWS_LIM)
                begin
                    pidx_next     = seek.index;
                    rbp_next      = seek.rows_before;
                    scanning_next = seek.found;
                    if (seek.found)
                    begin
                        row_next  = seek.row;
                        wptr_next = seek.word_ptr;
                    end
                end
                else
                begin
                    row_next = row_inc[ROW_W-1:0];
                end
            end
        end

        result_next.fetch_addr = scanning_next ? wptr_next : '0;
        result_next.frame_done = !scanning_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pidx_reg     <= '0;
            rbp_reg      <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            wptr_reg     <= '0;
            scanning_reg <= 1'b0;
        end
        else if (advance)
        begin
            pidx_reg     <= pidx_next;
            rbp_reg      <= rbp_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            wptr_reg     <= wptr_next;
            scanning_reg <= scanning_next;
        end
    end

endmodule

[rtl/planar_partition_scanout.sv]
// ----------------------------------------------------------------------------
// planar_partition_scanout
// Three-plane scan-out engine with up to four display partitions.
//
// Input channel (in_valid/in_ready): kind 0 starts a frame, kind 1 carries
// the blue, red and green plane bytes of the word named by the last
// fetch_addr. Every accepted item gives exactly one result item on the
// output channel (out_valid/out_ready) with the pixel group, its row and
// column, the next fetch address and the frame-done flag.
// The result is registered at the edge that accepts the item. Throughput is
// one item per cycle while out_ready stays high; the scan state and the
// partition search (at most four partitions) settle within that cycle.
// A single result register holds the item; in_ready stays high while that
// register is empty or being drained, so a stalled receiver holds the
// input side off after one item, without loss.
// Configuration (cfg_we/cfg_index/cfg_data) is written to registers and
// read live by the scan logic.
// Reset clears the scan state to idle, the registers to zero and empties
// the result register.
// ----------------------------------------------------------------------------
module planar_partition_scanout
#(
    parameter int unsigned SCREEN_ROWS     = 400,
    parameter int unsigned SCREEN_COLS     = 640,
    parameter int unsigned PARTITION_COUNT = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pps_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [pps_pkg::PLANE_W-1:0]   plane_blue,
    input  logic [pps_pkg::PLANE_W-1:0]   plane_red,
    input  logic [pps_pkg::PLANE_W-1:0]   plane_green,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          pixels_valid,
    output logic [pps_pkg::GROUP_W-1:0]   pixel_group,
    output logic                          doubled,
    output logic [pps_pkg::ROW_W-1:0]     row,
    output logic [pps_pkg::COL_W-1:0]     column,
    output logic [pps_pkg::ADDR_W-1:0]    fetch_addr,
    output logic                          frame_done
);
    import pps_pkg::*;

    logic [LINES_W-1:0] active_lines_reg;
    part_words_t        part_words_reg;
    result_t            result_reg;
    result_t            result_next;
    logic               out_valid_reg;
    logic               advance;

    assign in_ready = !out_valid_reg || out_ready;
    assign advance  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_lines_reg <= '0;
            part_words_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACTIVE_LINES: active_lines_reg  <= cfg_data[LINES_W-1:0];
                CFG_PART_0:       part_words_reg[0] <= cfg_data;
                CFG_PART_1:       part_words_reg[1] <= cfg_data;
                CFG_PART_2:       part_words_reg[2] <= cfg_data;
                CFG_PART_3:       part_words_reg[3] <= cfg_data;
                default:          ;
            endcase
        end
    end

    pps_scan_ctrl
    #(
        .SCREEN_ROWS     (SCREEN_ROWS),
        .SCREEN_COLS     (SCREEN_COLS),
        .PARTITION_COUNT (PARTITION_COUNT)
    )
    u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .kind         (kind),
        .plane_blue   (plane_blue),
        .plane_red    (plane_red),
        .plane_green  (plane_green),
        .active_lines (active_lines_reg),
        .part_words   (part_words_reg),
        .result_next  (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixels_valid = result_reg.pixels_valid;
    assign pixel_group  = result_reg.pixel_group;
    assign doubled      = result_reg.doubled;
    assign row          = result_reg.row;
    assign column       = result_reg.column;
    assign fetch_addr   = result_reg.fetch_addr;
    assign frame_done   = result_reg.frame_done;

endmodule
